FILE: hdl/lca_pkg.sv
package lca_pkg;

   // default board dimensions
   localparam int MAX_WIDTH_DEF  = 32;
   localparam int MAX_HEIGHT_DEF = 32;

   // request field widths
   localparam int CMD_W = 2;
   localparam int ROW_W = 5;
   localparam int COL_W = 5;

   // size registers and position compares (covers sizes up to 63)
   localparam int            SIZE_W     = 6;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
   localparam int            POS_W      = 7;

   // configuration bus
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // request commands
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

   // register select, taken from the word address bit
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // per-row control from the sequencer
   typedef struct packed {
      logic write_en;
      logic advance_en;
      logic value;
   } lca_cell_ctrl_type;

endpackage

FILE: hdl/lca_row_cell.sv
module lca_row_cell #(
   parameter int MAX_WIDTH = lca_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lca_pkg::lca_cell_ctrl_type ctrl,
   input  logic [MAX_WIDTH-1:0]       wr_mask,
   input  logic [MAX_WIDTH-1:0]       col_mask,
   input  logic                       row_active,
   input  logic [MAX_WIDTH-1:0]       up_row,
   input  logic [MAX_WIDTH-1:0]       down_row,
   output logic [MAX_WIDTH-1:0]       row_q,
   output logic                       alive
);
   import lca_pkg::*;

   logic [MAX_WIDTH-1:0] row_ff;
   logic [MAX_WIDTH-1:0] row_in;
   logic                 alive_ff;
   logic [MAX_WIDTH-1:0] own;
   logic [MAX_WIDTH+1:0] up_pad;
   logic [MAX_WIDTH+1:0] own_pad;
   logic [MAX_WIDTH+1:0] down_pad;
   logic [MAX_WIDTH-1:0] next_row;

   assign own      = row_ff & col_mask;
   assign up_pad   = {1'b0, up_row, 1'b0};
   assign own_pad  = {1'b0, own, 1'b0};
   assign down_pad = {1'b0, down_row, 1'b0};

   // b3/s23 rule per column, padded edges count as dead
   always_comb begin
      logic [3:0] cnt;
      cnt = 4'd0;
      for (int j = 0; j < MAX_WIDTH; j++) begin
         cnt = 4'(up_pad[j]) + 4'(up_pad[j+1]) + 4'(up_pad[j+2])
             + 4'(own_pad[j]) + 4'(own_pad[j+2])
             + 4'(down_pad[j]) + 4'(down_pad[j+1]) + 4'(down_pad[j+2]);
         next_row[j] = (cnt == 4'd3) | (own[j] & (cnt == 4'd2));
      end
   end

   // inactive cells keep their bits across an advance
   always_comb begin
      row_in = row_ff;
      if (ctrl.write_en) begin
         row_in = (row_ff & ~wr_mask) | (wr_mask & {MAX_WIDTH{ctrl.value}});
      end else if (ctrl.advance_en && row_active) begin
         row_in = (next_row & col_mask) | (row_ff & ~col_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         alive_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         alive_ff <= row_active & (|own);
      end
   end

   assign row_q = row_ff;
   assign alive = alive_ff;

endmodule

FILE: hdl/life_cell_array_core.sv
// a request passes the execute, row-flag and response steps of the sequencer
//   before its result strobe; a new request is taken only once the sequencer is
//   idle again (busy low); the whole board advances in the execute step
// reset: synchronous, clears every cell and sets both sizes to 32
// results are shown for one cycle on rsp_valid; the receiver cannot stall
module life_cell_array_core #(
   parameter int MAX_WIDTH  = lca_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lca_pkg::MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [lca_pkg::CMD_W-1:0]   req_command,
   input  logic [lca_pkg::ROW_W-1:0]   req_row,
   input  logic [lca_pkg::COL_W-1:0]   req_col,
   input  logic                        req_cell_value,
   output logic                        rsp_valid,
   output logic                        rsp_read_alive,
   output logic                        rsp_all_dead,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lca_pkg::ADDR_W-1:0]  paddr,
   input  logic [lca_pkg::DATA_W-1:0]  pwdata,
   output logic [lca_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import lca_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [SIZE_W-1:0]    width_ff, height_ff;
   logic [CMD_W-1:0]     cmd_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [COL_W-1:0]     col_ff;
   logic                 value_ff;
   logic [MAX_WIDTH-1:0] rd_word_ff, rd_word_in;
   logic                 read_bit_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_read_alive_ff;
   logic                 rsp_all_dead_ff;

   logic                 accept;
   logic                 cfg_write;
   logic                 in_area;
   logic [MAX_WIDTH-1:0] col_mask;
   logic [MAX_WIDTH-1:0] col_onehot;
   logic [MAX_HEIGHT-1:0] row_active;
   logic [MAX_HEIGHT-1:0] row_sel;
   logic [MAX_HEIGHT-1:0] row_alive;
   logic [MAX_WIDTH-1:0] row_q     [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] row_mskd  [MAX_HEIGHT];

   assign accept    = start & ~busy;
   assign busy      = (state_ff != ST_IDLE);
   assign cfg_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (cfg_write) begin
         unique case (paddr[2])
            REG_WIDTH:  width_ff  <= pwdata[SIZE_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (paddr[2])
         REG_WIDTH:  prdata = DATA_W'(width_ff);
         REG_HEIGHT: prdata = DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // active area and position decode
   always_comb begin
      for (int j = 0; j < MAX_WIDTH; j++) begin
         col_mask[j]   = POS_W'(j) < POS_W'(width_ff);
         col_onehot[j] = POS_W'(col_ff) == POS_W'(j);
      end
      for (int i = 0; i < MAX_HEIGHT; i++) begin
         row_active[i] = POS_W'(i) < POS_W'(height_ff);
         row_sel[i]    = POS_W'(row_ff) == POS_W'(i);
      end
   end

   assign in_area = (POS_W'(row_ff) < POS_W'(height_ff))
                 && (POS_W'(row_ff) < POS_W'(MAX_HEIGHT))
                 && (POS_W'(col_ff) < POS_W'(width_ff))
                 && (POS_W'(col_ff) < POS_W'(MAX_WIDTH));

   // row cells, each fed with its masked neighbor rows
   for (genvar i = 0; i < MAX_HEIGHT; i++) begin : gen_rows
      lca_cell_ctrl_type    ctrl;
      logic [MAX_WIDTH-1:0] up_row;
      logic [MAX_WIDTH-1:0] down_row;

      assign row_mskd[i] = row_active[i] ? (row_q[i] & col_mask) : '0;

      if (i == 0) begin : gen_top
         assign up_row = '0;
      end else begin : gen_up
         assign up_row = row_mskd[i-1];
      end

      if (i == MAX_HEIGHT - 1) begin : gen_bottom
         assign down_row = '0;
      end else begin : gen_down
         assign down_row = row_mskd[i+1];
      end

      assign ctrl.write_en   = (state_ff == ST_EXEC) && (cmd_ff == CMD_WRITE)
                            && in_area && row_sel[i];
      assign ctrl.advance_en = (state_ff == ST_EXEC) && (cmd_ff == CMD_ADVANCE);
      assign ctrl.value      = value_ff;

      lca_row_cell #(
         .MAX_WIDTH (MAX_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .wr_mask    (col_onehot),
         .col_mask   (col_mask),
         .row_active (row_active[i]),
         .up_row     (up_row),
         .down_row   (down_row),
         .row_q      (row_q[i]),
         .alive      (row_alive[i])
      );
   end

   // row select for a read
   always_comb begin
      rd_word_in = '0;
      for (int i = 0; i < MAX_HEIGHT; i++) begin
         rd_word_in = rd_word_in | (row_q[i] & {MAX_WIDTH{row_sel[i]}});
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_SCAN;
         ST_SCAN: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   // request latch, read path and response registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         row_ff   <= req_row;
         col_ff   <= req_col;
         value_ff <= req_cell_value;
      end
      if (state_ff == ST_EXEC) begin
         rd_word_ff <= rd_word_in;
      end
      if (state_ff == ST_SCAN) begin
         read_bit_ff <= (cmd_ff == CMD_READ) && in_area && (|(rd_word_ff & col_onehot));
      end
      if (state_ff == ST_DONE) begin
         rsp_read_alive_ff <= read_bit_ff;
         rsp_all_dead_ff   <= ~(|row_alive);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_alive = rsp_read_alive_ff;
   assign rsp_all_dead   = rsp_all_dead_ff;

endmodule

FILE: dv/life_cell_array_checker.sv
`timescale 1ns / 1ps

module life_cell_array_checker #(
   parameter int MAX_WIDTH  = lca_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lca_pkg::MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [lca_pkg::CMD_W-1:0]   req_command,
   input  logic [lca_pkg::ROW_W-1:0]   req_row,
   input  logic [lca_pkg::COL_W-1:0]   req_col,
   input  logic                        req_cell_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_read_alive,
   input  logic                        rsp_all_dead,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic                        pready,
   input  logic [lca_pkg::ADDR_W-1:0]  paddr,
   input  logic [lca_pkg::DATA_W-1:0]  pwdata,
   output int                          error_count,
   output int                          outstanding
);

   typedef struct packed {
      logic read_alive;
      logic all_dead;
   } cell_report_type;

   // shadow of the board and the size registers
   logic [MAX_HEIGHT-1:0][MAX_WIDTH-1:0] grid;
   logic [lca_pkg::SIZE_W-1:0]           width_reg;
   logic [lca_pkg::SIZE_W-1:0]           height_reg;

   cell_report_type pending_reports [$];
   int              fail_tally;

   // sizes above the array saturate to the array size
   function automatic int active_span(input logic [lca_pkg::SIZE_W-1:0] size, input int limit);
      return (int'(size) > limit) ? limit : int'(size);
   endfunction

   // apply one request to the shadow board and return the report it produces
   function automatic cell_report_type run_life_command(
      input logic [lca_pkg::CMD_W-1:0] cmd,
      input logic [lca_pkg::ROW_W-1:0] row,
      input logic [lca_pkg::COL_W-1:0] col,
      input logic                      value
   );
      int                                   w;
      int                                   h;
      int                                   count;
      logic                                 in_area;
      logic [MAX_HEIGHT-1:0][MAX_WIDTH-1:0] next_grid;
      cell_report_type                      rep;
      w = active_span(width_reg, MAX_WIDTH);
      h = active_span(height_reg, MAX_HEIGHT);
      in_area = (int'(row) < h) && (int'(col) < w);
      rep.read_alive = 1'b0;
      case (cmd)
         lca_pkg::CMD_WRITE: begin
            if (in_area) grid[row][col] = value;
         end
         lca_pkg::CMD_READ: begin
            if (in_area) rep.read_alive = grid[row][col];
         end
         lca_pkg::CMD_ADVANCE: begin
            // cells outside the active window keep their bits
            next_grid = grid;
            for (int r = 0; r < h; r++) begin
               for (int c = 0; c < w; c++) begin
                  count = 0;
                  for (int dr = -1; dr <= 1; dr++) begin
                     for (int dc = -1; dc <= 1; dc++) begin
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < h &&
                            c + dc >= 0 && c + dc < w) begin
                           count += int'(grid[r+dr][c+dc]);
                        end
                     end
                  end
                  next_grid[r][c] = grid[r][c] ? (count == 2 || count == 3) : (count == 3);
               end
            end
            grid = next_grid;
         end
         default: begin
         end
      endcase
      // empty flag covers the active window only
      rep.all_dead = 1'b1;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (grid[r][c]) rep.all_dead = 1'b0;
         end
      end
      return rep;
   endfunction

   always @(posedge clock) begin
      cell_report_type want;
      if (reset) begin
         grid = '0;
         width_reg = lca_pkg::SIZE_RESET;
         height_reg = lca_pkg::SIZE_RESET;
         pending_reports.delete();
      end else begin
         // size register writes, register picked by the word address bit
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == lca_pkg::REG_WIDTH) begin
               width_reg = pwdata[lca_pkg::SIZE_W-1:0];
            end else begin
               height_reg = pwdata[lca_pkg::SIZE_W-1:0];
            end
         end
         // compare each result with the oldest prediction
         if (rsp_valid === 1'b1) begin
            if (pending_reports.size() == 0) begin
               $error("result with no request waiting: read_alive %b all_dead %b",
                      rsp_read_alive, rsp_all_dead);
               fail_tally++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_read_alive !== want.read_alive) begin
                  $error("read_alive: expected %b, got %b", want.read_alive, rsp_read_alive);
                  fail_tally++;
               end
               if (rsp_all_dead !== want.all_dead) begin
                  $error("all_dead: expected %b, got %b", want.all_dead, rsp_all_dead);
                  fail_tally++;
               end
            end
         end
         // predict each accepted request
         if (start && !busy) begin
            pending_reports.push_back(run_life_command(req_command, req_row, req_col,
                                                       req_cell_value));
         end
      end
      outstanding <= pending_reports.size();
      error_count <= fail_tally;
   end

endmodule

FILE: dv/tb_life_cell_array_core.sv
`timescale 1ns / 1ps

module tb_life_cell_array_core;

   localparam logic [lca_pkg::CMD_W-1:0]  CMD_NOP     = 2'd3;
   localparam logic [lca_pkg::ADDR_W-1:0] WIDTH_ADDR  = {lca_pkg::REG_WIDTH, 2'b00};
   localparam logic [lca_pkg::ADDR_W-1:0] HEIGHT_ADDR = {lca_pkg::REG_HEIGHT, 2'b00};
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_REQUESTS = 75;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 200000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [lca_pkg::CMD_W-1:0]   req_command = '0;
   logic [lca_pkg::ROW_W-1:0]   req_row = '0;
   logic [lca_pkg::COL_W-1:0]   req_col = '0;
   logic                        req_cell_value = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_read_alive;
   logic                        rsp_all_dead;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [lca_pkg::ADDR_W-1:0]  paddr = '0;
   logic [lca_pkg::DATA_W-1:0]  pwdata = '0;
   logic [lca_pkg::DATA_W-1:0]  prdata;
   logic                        pready;

   int error_count;
   int outstanding;
   int sender_idle_pct = 8;
   int cur_width = 32;
   int cur_height = 32;
   int n_write, n_read, n_advance, n_nop, n_sizes;
   int cycle_count;

   always #4 clock = ~clock;

   life_cell_array_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_alive (rsp_read_alive),
      .rsp_all_dead   (rsp_all_dead),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   life_cell_array_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_alive (rsp_read_alive),
      .rsp_all_dead   (rsp_all_dead),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .error_count    (error_count),
      .outstanding    (outstanding)
   );

   // send one request, with an occasional idle gap in front of it
   task automatic issue(input logic [lca_pkg::CMD_W-1:0] cmd, input int row, input int col,
                        input logic value);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_row <= row[lca_pkg::ROW_W-1:0];
      req_col <= col[lca_pkg::COL_W-1:0];
      req_cell_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      case (cmd)
         lca_pkg::CMD_WRITE:   n_write++;
         lca_pkg::CMD_READ:    n_read++;
         lca_pkg::CMD_ADVANCE: n_advance++;
         default:              n_nop++;
      endcase
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // setup and access phases, written when pready is seen in the access phase
   task automatic csr_write(input logic [lca_pkg::ADDR_W-1:0] addr, input int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= lca_pkg::DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_board_size(input int w, input int h);
      drain();
      csr_write(WIDTH_ADDR, w);
      csr_write(HEIGHT_ADDR, h);
      cur_width = (w > 32) ? 32 : w;
      cur_height = (h > 32) ? 32 : h;
      n_sizes++;
   endtask

   // mostly inside the active window, sometimes anywhere on the array
   function automatic int pick_pos(input int span);
      if (span == 0 || $urandom_range(9) == 0) return $urandom_range(31);
      return $urandom_range(span - 1);
   endfunction

   task automatic run_random_phase(input int quota);
      int done;
      int roll;
      done = 0;
      // seed a live cluster so the pattern has something to evolve
      repeat (8 + $urandom_range(8)) begin
         issue(lca_pkg::CMD_WRITE, pick_pos(cur_height), pick_pos(cur_width),
               $urandom_range(99) < 70);
         done++;
      end
      while (done < quota) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            issue(lca_pkg::CMD_WRITE, pick_pos(cur_height), pick_pos(cur_width),
                  $urandom_range(99) < 55);
         end else if (roll < 70) begin
            issue(lca_pkg::CMD_READ, pick_pos(cur_height), pick_pos(cur_width),
                  $urandom_range(1));
         end else if (roll < 93) begin
            issue(lca_pkg::CMD_ADVANCE, $urandom_range(31), $urandom_range(31),
                  $urandom_range(1));
         end else begin
            issue(CMD_NOP, $urandom_range(31), $urandom_range(31), $urandom_range(1));
         end
         done++;
      end
   endtask

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("tb_life_cell_array_core failed");
      $finish;
   end

   initial begin
      int w;
      int h;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty board after reset, corners of the full board
      issue(lca_pkg::CMD_READ, 0, 0, 1'b0);
      issue(lca_pkg::CMD_WRITE, 0, 0, 1'b1);
      issue(lca_pkg::CMD_WRITE, 31, 31, 1'b1);
      issue(lca_pkg::CMD_READ, 31, 31, 1'b0);
      issue(CMD_NOP, 31, 31, 1'b1);
      // lone cells die on the next generation
      issue(lca_pkg::CMD_ADVANCE, 0, 0, 1'b0);
      issue(lca_pkg::CMD_READ, 0, 0, 1'b0);
      // three cells in the top-left corner give birth to a block
      issue(lca_pkg::CMD_WRITE, 0, 0, 1'b1);
      issue(lca_pkg::CMD_WRITE, 0, 1, 1'b1);
      issue(lca_pkg::CMD_WRITE, 1, 0, 1'b1);
      issue(lca_pkg::CMD_ADVANCE, 31, 31, 1'b1);
      issue(lca_pkg::CMD_READ, 1, 1, 1'b0);
      // blinker on the bottom edge, clipped with no wraparound
      issue(lca_pkg::CMD_WRITE, 31, 29, 1'b1);
      issue(lca_pkg::CMD_WRITE, 31, 30, 1'b1);
      issue(lca_pkg::CMD_WRITE, 31, 31, 1'b1);
      issue(lca_pkg::CMD_ADVANCE, 0, 0, 1'b0);
      issue(lca_pkg::CMD_READ, 30, 30, 1'b0);
      // marker cell that a small board must leave alone
      issue(lca_pkg::CMD_WRITE, 20, 20, 1'b1);
      set_board_size(3, 3);
      issue(lca_pkg::CMD_READ, 20, 20, 1'b0);
      issue(lca_pkg::CMD_WRITE, 20, 20, 1'b0);
      issue(lca_pkg::CMD_ADVANCE, 0, 0, 1'b0);
      // zero width: nothing is active
      set_board_size(0, 32);
      issue(lca_pkg::CMD_WRITE, 1, 1, 1'b1);
      issue(lca_pkg::CMD_READ, 0, 0, 1'b0);
      // oversized sizes saturate and the marker shows again
      set_board_size(63, 63);
      issue(lca_pkg::CMD_READ, 20, 20, 1'b0);

      // random phases over a spread of board sizes
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < RANDOM_PHASES / 3) sender_idle_pct = 8;
         else if (p < 2 * RANDOM_PHASES / 3) sender_idle_pct = 45;
         else sender_idle_pct = 0;
         case (p)
            0: set_board_size(32, 32);
            1: set_board_size(1, 1);
            2: set_board_size(63, 7);
            3: set_board_size(6, 40);
            4: set_board_size(33, 2);
            default: begin
               w = ($urandom_range(5) == 0) ? 32 : $urandom_range(2, 12);
               h = ($urandom_range(5) == 0) ? 32 : $urandom_range(2, 12);
               set_board_size(w, h);
            end
         endcase
         run_random_phase(PHASE_REQUESTS);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests: %0d writes, %0d reads, %0d advances, %0d no-ops",
               n_write + n_read + n_advance + n_nop, n_write, n_read, n_advance, n_nop);
      $display("across %0d board sizes, from zero and one up to oversized widths and heights",
               n_sizes);
      if (error_count == 0) begin
         $display("tb_life_cell_array_core passed");
      end else begin
         $display("tb_life_cell_array_core failed");
      end
      $finish;
   end

endmodule

FILE: life_cell_array_core.f
hdl/lca_pkg.sv
hdl/lca_row_cell.sv
hdl/life_cell_array_core.sv
dv/life_cell_array_checker.sv
dv/tb_life_cell_array_core.sv
